>>> sv/bpfa_pkg.sv
// Shared constants and codes for the bitmap page frame allocator.
package bpfa_pkg;

    localparam int REG_W            = 17;
    localparam int CMD_W            = 2;
    localparam int ADDR_W           = 40;
    localparam int PADDR_W          = 28;
    localparam int STATUS_W         = 2;
    localparam int CFG_INDEX_W      = 2;
    localparam int PAGE_SHIFT       = 12;

    localparam int DEF_MAX_PAGES     = 65536;
    localparam int DEF_MAP_WORD_BITS = 32;

    localparam logic [REG_W-1:0] RESET_PAGE_COUNT = REG_W'(65536);
    localparam logic [REG_W-1:0] RESET_FIRST_PAGE = REG_W'(512);

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_PAGE  = 2'd1;

endpackage

>>> sv/bpfa_ram.sv
// Generic single-port synchronous RAM with registered read.
module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> sv/bitmap_page_frame_allocator.sv
// Bitmap page frame allocator: next-fit page search over a used map held in RAM.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_stall, command, address     | to block
//   out     | out_valid, out_stall, page_address,      | from block
//           | status, pages_used                       |
//   cfg     | cfg_write, cfg_index, cfg_data           | to block
//
// Free and reserve: the result follows a read, a check and a write back of the map word;
// the read is skipped when the page is out of range or the command is unused.
// Allocate: map words are scanned from the hint upward until a free page or the limit is met
// (no scan when the hint is at or past the limit); each word costs a RAM read and a check.
// After reset a clearing pass writes every map word before any word is accepted on in.
// The next in word is taken while a result waits on out.
module bitmap_page_frame_allocator #(
    parameter int MAX_PAGES     = bpfa_pkg::DEF_MAX_PAGES,
    parameter int MAP_WORD_BITS = bpfa_pkg::DEF_MAP_WORD_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bpfa_pkg::CMD_W-1:0]        command,
    input  logic [bpfa_pkg::ADDR_W-1:0]       address,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bpfa_pkg::PADDR_W-1:0]      page_address,
    output logic [bpfa_pkg::STATUS_W-1:0]     status,
    output logic [bpfa_pkg::REG_W-1:0]        pages_used,
    input  logic                              cfg_write,
    input  logic [bpfa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bpfa_pkg::REG_W-1:0]        cfg_data
);

    localparam int RW        = bpfa_pkg::REG_W;
    localparam int BIT_W     = $clog2(MAP_WORD_BITS);
    localparam int WB        = 1 << BIT_W;
    localparam int MAP_WORDS = (MAX_PAGES + WB - 1) / WB;
    localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDX_W     = RW - BIT_W;
    localparam int PAGE_IN_W = bpfa_pkg::ADDR_W - bpfa_pkg::PAGE_SHIFT;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                        state_reg, state_next;
    logic [WADDR_W-1:0]                clr_reg, clr_next;
    logic [RW-1:0]                     page_count_reg, page_count_next;
    logic [RW-1:0]                     hint_reg, hint_next;
    logic [RW-1:0]                     used_reg, used_next;
    logic [RW-1:0]                     cur_page_reg, cur_page_next;
    logic [bpfa_pkg::CMD_W-1:0]        cmd_reg, cmd_next;
    logic [bpfa_pkg::PADDR_W-1:0]      res_addr_reg, res_addr_next;
    logic [bpfa_pkg::STATUS_W-1:0]     res_status_reg, res_status_next;
    logic                              out_valid_reg, out_valid_next;
    logic [bpfa_pkg::PADDR_W-1:0]      out_addr_reg, out_addr_next;
    logic [bpfa_pkg::STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [RW-1:0]                     out_used_reg, out_used_next;

    logic [RW-1:0]                     lim;
    logic [PAGE_IN_W-1:0]              in_page;
    logic                              in_take;
    logic [IDX_W-1:0]                  cur_word;
    logic [IDX_W+WADDR_W-1:0]          word_ext;
    logic [WADDR_W-1:0]                ram_addr;
    logic                              ram_we;
    logic [WB-1:0]                     ram_wdata;
    logic [WB-1:0]                     ram_rdata;
    logic [BIT_W-1:0]                  cur_bit;
    logic [RW-1:0]                     base;
    logic [RW-1:0]                     lim_off;
    logic [WB-1:0]                     lo_mask;
    logic [WB-1:0]                     hi_mask;
    logic [WB-1:0]                     cand;
    logic                              found;
    logic [BIT_W-1:0]                  found_bit;
    logic [RW-1:0]                     found_page;
    logic [RW:0]                       nxt_page;
    logic [WB-1:0]                     cur_onehot;

    // limit saturates at MAX_PAGES
    always_comb
    begin
        if (32'(page_count_reg) > 32'(MAX_PAGES))
        begin
            lim = RW'(MAX_PAGES);
        end
        else
        begin
            lim = page_count_reg;
        end
    end

    assign in_page  = address[bpfa_pkg::ADDR_W-1:bpfa_pkg::PAGE_SHIFT];
    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;

    assign cur_word = cur_page_reg[RW-1:BIT_W];
    assign cur_bit  = cur_page_reg[BIT_W-1:0];
    assign word_ext = {{WADDR_W{1'b0}}, cur_word};
    assign base     = {cur_word, {BIT_W{1'b0}}};
    assign lim_off  = lim - base;
    assign lo_mask  = {WB{1'b1}} << cur_bit;
    assign hi_mask  = (lim_off >= RW'(WB)) ? {WB{1'b1}}
                                           : ((WB'(1) << lim_off[BIT_W-1:0]) - WB'(1));
    assign cand     = ~ram_rdata & lo_mask & hi_mask;
    assign nxt_page = {1'b0, base} + (RW+1)'(WB);
    assign cur_onehot = WB'(1) << cur_bit;

    // lowest free bit in range
    always_comb
    begin
        found     = 1'b0;
        found_bit = '0;
        for (int j = WB - 1; j >= 0; j--)
        begin
            if (cand[j])
            begin
                found     = 1'b1;
                found_bit = BIT_W'(j);
            end
        end
    end

    assign found_page = {cur_word, found_bit};

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        page_count_next = page_count_reg;
        hint_next       = hint_reg;
        used_next       = used_reg;
        cur_page_next   = cur_page_reg;
        cmd_next        = cmd_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        out_used_next   = out_used_reg;
        ram_we          = 1'b0;
        ram_wdata       = ram_rdata;
        ram_addr        = word_ext[WADDR_W-1:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_write)
        begin
            case (cfg_index)
                bpfa_pkg::CFG_PAGE_COUNT:
                begin
                    page_count_next = cfg_data;
                end
                bpfa_pkg::CFG_FIRST_PAGE:
                begin
                    hint_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                ram_addr  = clr_reg;
                clr_next  = clr_reg + WADDR_W'(1);
                if (clr_reg == WADDR_W'(MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_take)
                begin
                    cmd_next        = command;
                    res_addr_next   = '0;
                    res_status_next = bpfa_pkg::ST_DONE;
                    state_next      = S_DONE;
                    case (command)
                        bpfa_pkg::CMD_ALLOC:
                        begin
                            if (hint_reg >= lim)
                            begin
                                res_status_next = bpfa_pkg::ST_NO_FREE;
                            end
                            else
                            begin
                                cur_page_next = hint_reg;
                                state_next    = S_READ;
                            end
                        end
                        bpfa_pkg::CMD_FREE, bpfa_pkg::CMD_RESERVE:
                        begin
                            if (in_page >= PAGE_IN_W'(lim))
                            begin
                                res_status_next = bpfa_pkg::ST_RANGE;
                            end
                            else
                            begin
                                cur_page_next = in_page[RW-1:0];
                                state_next    = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_DONE;
                case (cmd_reg)
                    bpfa_pkg::CMD_ALLOC:
                    begin
                        if (found)
                        begin
                            ram_we        = 1'b1;
                            ram_wdata     = ram_rdata | (WB'(1) << found_bit);
                            used_next     = used_reg + RW'(1);
                            hint_next     = found_page + RW'(1);
                            res_addr_next = {
                                found_page[bpfa_pkg::PADDR_W-bpfa_pkg::PAGE_SHIFT-1:0],
                                {bpfa_pkg::PAGE_SHIFT{1'b0}}
                            };
                        end
                        else if (nxt_page >= {1'b0, lim})
                        begin
                            res_status_next = bpfa_pkg::ST_NO_FREE;
                        end
                        else
                        begin
                            cur_page_next = nxt_page[RW-1:0];
                            state_next    = S_READ;
                        end
                    end
                    bpfa_pkg::CMD_FREE:
                    begin
                        if (ram_rdata[cur_bit])
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata & ~cur_onehot;
                            used_next = used_reg - RW'(1);
                        end
                    end
                    default:
                    begin
                        if (!ram_rdata[cur_bit])
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata | cur_onehot;
                            used_next = used_reg + RW'(1);
                        end
                    end
                endcase
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                    out_used_next   = used_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            page_count_reg <= bpfa_pkg::RESET_PAGE_COUNT;
            hint_reg       <= bpfa_pkg::RESET_FIRST_PAGE;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            page_count_reg <= page_count_next;
            hint_reg       <= hint_next;
            used_reg       <= used_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_page_reg   <= cur_page_next;
        cmd_reg        <= cmd_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
        out_used_reg   <= out_used_next;
    end

    bpfa_ram #(
        .WIDTH (WB),
        .DEPTH (MAP_WORDS),
        .AW    (WADDR_W)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign out_valid    = out_valid_reg;
    assign page_address = out_addr_reg;
    assign status       = out_status_reg;
    assign pages_used   = out_used_reg;

endmodule

>>> verif/tb_bitmap_page_frame_allocator.sv
// Self-checking testbench for the bitmap page frame allocator: directed and random words.
`timescale 1ns / 100ps

module tb_bitmap_page_frame_allocator;

    localparam int CMD_W       = bpfa_pkg::CMD_W;
    localparam int ADDR_W      = bpfa_pkg::ADDR_W;
    localparam int PADDR_W     = bpfa_pkg::PADDR_W;
    localparam int STATUS_W    = bpfa_pkg::STATUS_W;
    localparam int REG_W       = bpfa_pkg::REG_W;
    localparam int CFG_INDEX_W = bpfa_pkg::CFG_INDEX_W;
    localparam int PAGE_SHIFT  = bpfa_pkg::PAGE_SHIFT;

    localparam int MAP_PAGES     = bpfa_pkg::DEF_MAX_PAGES;
    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 144;

    localparam logic [CMD_W-1:0]       CMD_UNUSED  = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam int unsigned PHASE_PAGES [PHASES] =
        '{64, 65536, 131071, 0, 200, 1000, 33, 4096};
    localparam int unsigned PHASE_FIRST [PHASES] =
        '{0, 512, 65500, 0, 131071, 37, 30, 4000};

    typedef struct packed {
        logic [PADDR_W-1:0]  page_address;
        logic [STATUS_W-1:0] status;
        logic [REG_W-1:0]    pages_used;
    } alloc_reply_t;

    class frame_book;
        bit               used_map [MAP_PAGES];
        logic [REG_W-1:0] used_total;
        logic [REG_W-1:0] hint;
        logic [REG_W-1:0] page_count;
        logic [REG_W-1:0] first_page;
        alloc_reply_t     reply_fifo [$];
        int               faults;

        function new();
            used_total = '0;
            hint       = bpfa_pkg::RESET_FIRST_PAGE;
            page_count = bpfa_pkg::RESET_PAGE_COUNT;
            first_page = bpfa_pkg::RESET_FIRST_PAGE;
            faults     = 0;
        endfunction

        function int unsigned limit();
            return (page_count > MAP_PAGES) ? MAP_PAGES : page_count;
        endfunction

        function int pending();
            return reply_fifo.size();
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [REG_W-1:0] val);
            if (idx == bpfa_pkg::CFG_PAGE_COUNT)
            begin
                page_count = val;
            end
            else if (idx == bpfa_pkg::CFG_FIRST_PAGE)
            begin
                first_page = val;
                hint       = val;
            end
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
            alloc_reply_t r;
            int unsigned  lim;
            int unsigned  pg;
            int unsigned  i;
            r   = '0;
            lim = limit();
            pg  = addr[ADDR_W-1:PAGE_SHIFT];
            if (cmd == bpfa_pkg::CMD_ALLOC)
            begin
                r.status = bpfa_pkg::ST_NO_FREE;
                for (i = hint; i < lim; i++)
                begin
                    if (!used_map[i])
                    begin
                        used_map[i]    = 1'b1;
                        used_total     = used_total + 1'b1;
                        hint           = REG_W'(i + 1);
                        r.page_address = PADDR_W'(i << PAGE_SHIFT);
                        r.status       = bpfa_pkg::ST_DONE;
                        break;
                    end
                end
            end
            else if (cmd == bpfa_pkg::CMD_FREE || cmd == bpfa_pkg::CMD_RESERVE)
            begin
                if (pg >= lim)
                begin
                    r.status = bpfa_pkg::ST_RANGE;
                end
                else if (cmd == bpfa_pkg::CMD_FREE)
                begin
                    if (used_map[pg])
                    begin
                        used_map[pg] = 1'b0;
                        used_total   = used_total - 1'b1;
                    end
                end
                else if (!used_map[pg])
                begin
                    used_map[pg] = 1'b1;
                    used_total   = used_total + 1'b1;
                end
            end
            r.pages_used = used_total;
            reply_fifo.push_back(r);
        endfunction

        function void flag(string what, alloc_reply_t want, alloc_reply_t got);
            faults++;
            if (faults <= 10)
                $display({"%0t mismatch (%s): page_address exp %h act %h, ",
                          "status exp %0d act %0d, pages_used exp %0d act %0d"},
                         $realtime, what, want.page_address, got.page_address,
                         want.status, got.status, want.pages_used, got.pages_used);
        endfunction

        function void check_reply(alloc_reply_t got);
            alloc_reply_t want;
            if (reply_fifo.size() == 0)
            begin
                flag("reply with nothing outstanding", '0, got);
                return;
            end
            want = reply_fifo.pop_front();
            if (got.page_address !== want.page_address || got.status !== want.status ||
                got.pages_used !== want.pages_used)
                flag("field", want, got);
        endfunction

        function void close();
            if (reply_fifo.size() != 0)
            begin
                faults++;
                $display("%0d replies never arrived", reply_fifo.size());
            end
        endfunction
    endclass

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   in_valid     = 1'b0;
    logic                   in_stall;
    logic [CMD_W-1:0]       command      = bpfa_pkg::CMD_ALLOC;
    logic [ADDR_W-1:0]      address      = '0;
    logic                   out_valid;
    logic                   out_stall    = 1'b0;
    logic [PADDR_W-1:0]     page_address;
    logic [STATUS_W-1:0]    status;
    logic [REG_W-1:0]       pages_used;
    logic                   cfg_write    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = bpfa_pkg::CFG_PAGE_COUNT;
    logic [REG_W-1:0]       cfg_data     = '0;

    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        quiet          = 0;
    frame_book book           = new();

    bitmap_page_frame_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .address      (address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .page_address (page_address),
        .status       (status),
        .pages_used   (pages_used),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            book.check_reply('{page_address, status, pages_used});
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        begin
            quiet <= 0;
        end
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    function automatic logic [ADDR_W-1:0] at_page(int unsigned pg);
        return {pg[ADDR_W-PAGE_SHIFT-1:0], PAGE_SHIFT'($urandom)};
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        address  <= addr;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        book.note_request(cmd, addr);
    endtask

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [REG_W-1:0] val);
        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        book.write_reg(idx, val);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic make_word(output logic [CMD_W-1:0] cmd, output logic [ADDR_W-1:0] addr);
        int unsigned pick;
        int unsigned lim;
        int unsigned base;
        int unsigned pg;
        pick = $urandom_range(99);
        lim  = book.limit();
        base = (book.hint < lim) ? book.hint : lim;
        addr = ADDR_W'({$urandom, $urandom});
        pg   = 0;
        if (pick < 40)
        begin
            cmd = bpfa_pkg::CMD_ALLOC;
        end
        else if (pick < 88)
        begin
            cmd = (pick < 66) ? bpfa_pkg::CMD_FREE : bpfa_pkg::CMD_RESERVE;
            case ($urandom_range(3))
                0: pg = (lim == 0) ? $urandom_range(7) : $urandom_range(lim - 1);
                1: pg = (base > 32) ? base - 1 - $urandom_range(31) : $urandom_range(base);
                2: pg = (lim == 0) ? $urandom_range(1) : lim - 1 + $urandom_range(1);
                default: pg = $urandom_range(lim + 64);
            endcase
            addr = at_page(pg);
        end
        else
        begin
            cmd = (pick < 94) ? CMD_UNUSED
                              : ($urandom_range(1) ? bpfa_pkg::CMD_FREE : bpfa_pkg::CMD_RESERVE);
        end
    endtask

    initial
    begin
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_word(bpfa_pkg::CMD_ALLOC, {ADDR_W{1'b1}});
        send_word(bpfa_pkg::CMD_RESERVE, at_page(513));
        send_word(bpfa_pkg::CMD_ALLOC, '0);
        send_word(bpfa_pkg::CMD_RESERVE, at_page(513));
        send_word(bpfa_pkg::CMD_FREE, at_page(513));
        send_word(bpfa_pkg::CMD_FREE, at_page(513));
        send_word(bpfa_pkg::CMD_FREE, at_page(65536));
        send_word(bpfa_pkg::CMD_RESERVE, {ADDR_W{1'b1}});
        send_word(CMD_UNUSED, {ADDR_W{1'b1}});
        send_word(bpfa_pkg::CMD_RESERVE, at_page(65535));
        send_word(bpfa_pkg::CMD_RESERVE, at_page(0));
        send_word(bpfa_pkg::CMD_FREE, at_page(0));
        set_reg(bpfa_pkg::CFG_FIRST_PAGE, '0);
        send_word(bpfa_pkg::CMD_ALLOC, '0);
        send_word(bpfa_pkg::CMD_ALLOC, '0);
        set_reg(bpfa_pkg::CFG_FIRST_PAGE, REG_W'(65535));
        send_word(bpfa_pkg::CMD_ALLOC, '0);
        send_word(bpfa_pkg::CMD_FREE, at_page(65535));
        send_word(bpfa_pkg::CMD_ALLOC, '0);
        send_word(bpfa_pkg::CMD_ALLOC, '0);
        set_reg(bpfa_pkg::CFG_FIRST_PAGE, {REG_W{1'b1}});
        send_word(bpfa_pkg::CMD_ALLOC, '0);
        set_reg(bpfa_pkg::CFG_PAGE_COUNT, '0);
        send_word(bpfa_pkg::CMD_FREE, at_page(0));
        send_word(bpfa_pkg::CMD_ALLOC, '0);
        set_reg(bpfa_pkg::CFG_PAGE_COUNT, {REG_W{1'b1}});
        set_reg(bpfa_pkg::CFG_FIRST_PAGE, REG_W'(65534));
        send_word(bpfa_pkg::CMD_RESERVE, at_page(65535));
        send_word(bpfa_pkg::CMD_ALLOC, '0);
        set_reg(CFG_SPARE_2, REG_W'($urandom));
        set_reg(CFG_SPARE_3, {REG_W{1'b1}});
        send_word(bpfa_pkg::CMD_ALLOC, '0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_reg(bpfa_pkg::CFG_PAGE_COUNT, REG_W'(PHASE_PAGES[ph]));
            set_reg(bpfa_pkg::CFG_FIRST_PAGE, REG_W'(PHASE_FIRST[ph]));
            if (ph % 3 == 1)
                set_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, REG_W'($urandom));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                make_word(cmd, addr);
                send_word(cmd, addr);
            end
        end

        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        book.close();
        if (book.faults == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

>>> sim.f
sv/bpfa_pkg.sv
sv/bpfa_ram.sv
sv/bitmap_page_frame_allocator.sv
verif/tb_bitmap_page_frame_allocator.sv
